// ===== rtl/oofd_pkg.sv =====
// Package for the OOK pulse frame decoder: widths, register indexes and the
// structs passed between the decoder modules. Depends on nothing.
package oofd_pkg;

   localparam int LEN_W      = 16;
   localparam int TOL_W      = 7;
   localparam int CODE_W     = 32;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   // Holds a nominal length times (100 + tolerance), and a length times 100.
   localparam int PROD_W     = 24;

   localparam logic [TOL_W-1:0] TOL_FULL = 7'd100;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_HIGH = 3'd0,
      CSR_SYNC_LOW  = 3'd1,
      CSR_ZERO_HIGH = 3'd2,
      CSR_ZERO_LOW  = 3'd3,
      CSR_ONE_HIGH  = 3'd4,
      CSR_ONE_LOW   = 3'd5,
      CSR_INVERTED  = 3'd6,
      CSR_TOLERANCE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0] sync_high_us;
      logic [LEN_W-1:0] sync_low_us;
      logic [LEN_W-1:0] zero_high_us;
      logic [LEN_W-1:0] zero_low_us;
      logic [LEN_W-1:0] one_high_us;
      logic [LEN_W-1:0] one_low_us;
      logic             inverted_mode;
      logic [TOL_W-1:0] tolerance_percent;
   } cfg_type;

   // One pulse as captured at the input.
   typedef struct packed {
      logic             pulse_level;
      logic [LEN_W-1:0] pulse_length_us;
      logic             capture_end;
   } pulse_type;

   // What the frame control asks of the two pulse matchers.
   typedef struct packed {
      logic [LEN_W-1:0] nominal_a;
      logic             level_a;
      logic [LEN_W-1:0] nominal_b;
      logic             level_b;
   } match_req_type;

   typedef struct packed {
      logic fit_a;
      logic fit_b;
   } match_rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code_word;
      logic [COUNT_W-1:0] bit_count;
      logic               frame_ok;
   } result_type;

endpackage

// ===== rtl/oofd_req_if.sv =====
// Pulse input channel of the OOK pulse frame decoder.
// Depends on oofd_pkg for the field widths.
interface oofd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       pulse_level;
   logic [oofd_pkg::LEN_W-1:0] pulse_length_us;
   logic                       capture_end;

   modport source (output valid, pulse_level, pulse_length_us, capture_end, input ready);
   modport sink   (input valid, pulse_level, pulse_length_us, capture_end, output ready);
endinterface

// ===== rtl/oofd_rsp_if.sv =====
// Frame result channel of the OOK pulse frame decoder.
// Depends on oofd_pkg for the field widths.
interface oofd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [oofd_pkg::CODE_W-1:0]  code_word;
   logic [oofd_pkg::COUNT_W-1:0] bit_count;
   logic                         frame_ok;

   modport source (output valid, code_word, bit_count, frame_ok, input ready);
   modport sink   (input valid, code_word, bit_count, frame_ok, output ready);
endinterface

// ===== rtl/oofd_pulse_match.sv =====
// Checks one pulse against one nominal length within the tolerance band.
// Depends on oofd_pkg for widths.
module oofd_pulse_match (
   input  logic [oofd_pkg::LEN_W-1:0] nominal,
   input  logic [oofd_pkg::TOL_W-1:0] tolerance,
   input  logic                       want_level,
   input  logic                       level,
   input  logic [oofd_pkg::LEN_W-1:0] length,
   output logic                       fit
);

   logic [oofd_pkg::TOL_W-1:0]  tol_sat;
   logic [7:0]                  scale_lo;
   logic [7:0]                  scale_hi;
   logic [oofd_pkg::PROD_W-1:0] bound_lo;
   logic [oofd_pkg::PROD_W-1:0] bound_hi;
   logic [oofd_pkg::PROD_W-1:0] len_x100;

   // Tolerance above 100 percent acts as 100 percent.
   assign tol_sat  = (tolerance > oofd_pkg::TOL_FULL) ? oofd_pkg::TOL_FULL : tolerance;
   assign scale_lo = 8'(oofd_pkg::TOL_FULL) - 8'(tol_sat);
   assign scale_hi = 8'(oofd_pkg::TOL_FULL) + 8'(tol_sat);

   // Band edges scaled by 100, so no division is needed.
   assign bound_lo = oofd_pkg::PROD_W'(nominal) * oofd_pkg::PROD_W'(scale_lo);
   assign bound_hi = oofd_pkg::PROD_W'(nominal) * oofd_pkg::PROD_W'(scale_hi);
   assign len_x100 = (oofd_pkg::PROD_W'(length) << 6) + (oofd_pkg::PROD_W'(length) << 5)
                   + (oofd_pkg::PROD_W'(length) << 2);

   // floor(lo/100) <= L  is  lo <= 100L + 99;  L <= floor(hi/100)  is  100L <= hi.
   assign fit = (level == want_level)
             && (bound_lo <= len_x100 + oofd_pkg::PROD_W'(99))
             && (len_x100 <= bound_hi);

endmodule

// ===== rtl/oofd_frame_ctrl.sv =====
// Sync hunt and bit pair state machine of the OOK pulse frame decoder.
// Depends on oofd_pkg for the config, match and result structs.
module oofd_frame_ctrl #(
   parameter int MAX_BITS = 32,
   parameter int MIN_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     last,
   input  oofd_pkg::cfg_type        cfg,
   input  oofd_pkg::match_rsp_type  match_rsp,
   output oofd_pkg::match_req_type  match_req,
   output logic                     emit,
   output oofd_pkg::result_type     result
);

   localparam int CNT_W = $clog2(MAX_BITS + 1);

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SYNC2 = 2'd1,
      PH_BIT1  = 2'd2,
      PH_BIT2  = 2'd3
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic [1:0]                    halves_ff, halves_in;
   logic [oofd_pkg::CODE_W-1:0]   shift_ff, shift_in;
   logic [CNT_W-1:0]              bits_ff, bits_in;

   logic                          first_level;
   logic                          second_level;
   logic                          bit_zero;
   logic                          bit_one;
   logic [oofd_pkg::CODE_W-1:0]   shift_next;
   logic [CNT_W-1:0]              bits_next;
   logic [oofd_pkg::CODE_W-1:0]   emit_word;
   logic [CNT_W-1:0]              emit_bits;
   logic [7:0]                    emit_bits8;

   // In inverted mode each pair opens with a space.
   assign first_level  = ~cfg.inverted_mode;
   assign second_level = cfg.inverted_mode;

   // Pick the nominal lengths that this phase compares against.
   always_comb begin
      match_req.nominal_a = cfg.sync_high_us;
      match_req.level_a   = first_level;
      match_req.nominal_b = cfg.sync_high_us;
      match_req.level_b   = first_level;
      case (phase_ff)
         PH_HUNT: begin
            match_req.nominal_a = cfg.sync_high_us;
         end
         PH_SYNC2: begin
            match_req.nominal_a = cfg.sync_low_us;
            match_req.level_a   = second_level;
         end
         PH_BIT1: begin
            match_req.nominal_a = cfg.zero_high_us;
            match_req.nominal_b = cfg.one_high_us;
         end
         PH_BIT2: begin
            match_req.nominal_a = cfg.zero_low_us;
            match_req.level_a   = second_level;
            match_req.nominal_b = cfg.one_low_us;
            match_req.level_b   = second_level;
         end
         default: begin
            match_req.nominal_a = cfg.sync_high_us;
         end
      endcase
   end

   // Second half decision: zero wins when both fit.
   assign bit_zero   = halves_ff[0] && match_rsp.fit_a;
   assign bit_one    = !bit_zero && halves_ff[1] && match_rsp.fit_b;
   assign shift_next = {shift_ff[oofd_pkg::CODE_W-2:0], bit_one};
   assign bits_next  = bits_ff + CNT_W'(1);

   // Next state, and whether this pulse closes a frame.
   always_comb begin
      phase_in  = phase_ff;
      halves_in = halves_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      emit      = 1'b0;
      emit_word = shift_ff;
      emit_bits = bits_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (!last && match_rsp.fit_a) begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (match_rsp.fit_a) begin
               phase_in  = PH_BIT1;
               shift_in  = '0;
               bits_in   = '0;
               emit      = last;
               emit_word = '0;
               emit_bits = '0;
            end else if (!last && match_rsp.fit_b) begin
               phase_in = PH_SYNC2;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_BIT1: begin
            if ((!match_rsp.fit_a && !match_rsp.fit_b) || last) begin
               emit = 1'b1;
            end else begin
               halves_in = {match_rsp.fit_b, match_rsp.fit_a};
               phase_in  = PH_BIT2;
            end
         end
         PH_BIT2: begin
            if (!bit_zero && !bit_one) begin
               emit = 1'b1;
            end else begin
               shift_in  = shift_next;
               bits_in   = bits_next;
               halves_in = '0;
               phase_in  = PH_BIT1;
               emit_word = shift_next;
               emit_bits = bits_next;
               emit      = (32'(bits_next) >= 32'(MAX_BITS)) || last;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      // Every frame end restarts the hunt from a clean word.
      if (emit) begin
         phase_in  = PH_HUNT;
         halves_in = '0;
         shift_in  = '0;
         bits_in   = '0;
      end
   end

   // Result fields; the count saturates at 63.
   assign emit_bits8       = 8'(emit_bits);
   assign result.code_word = emit_word;
   assign result.bit_count = (emit_bits8 > 8'd63) ? 6'd63 : emit_bits8[5:0];
   assign result.frame_ok  = (emit_bits8 >= 8'(MIN_BITS));

   // State registers advance only when the pulse in the input stage is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         halves_ff <= '0;
         shift_ff  <= '0;
         bits_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         halves_ff <= halves_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
      end
   end

endmodule

// ===== rtl/ook_pulse_frame_decoder.sv =====
// Top level of the OOK pulse frame decoder: config registers, input and
// result registers. Depends on oofd_pkg, oofd_req_if, oofd_rsp_if,
// oofd_pulse_match and oofd_frame_ctrl.
//
//   Channel   Direction  Moves                                       Transfer
//   req_chan  in         pulse_level, pulse_length_us, capture_end   valid && ready
//   rsp_chan  out        code_word, bit_count, frame_ok              valid && ready
//   csr_*     in         csr_index, csr_wdata                        csr_we
//
// One pulse per cycle while no frame end waits for the result register; a result is
// registered from the pulse held in the input register when that pulse is consumed.
// The cycle is set by the length check: two 16x8 multiplies and two compares per matcher.
// Reset is synchronous and restores the hunt state and the default registers.
// A pulse that ends a frame waits in the input register while an earlier
// result is still untaken; other pulses keep flowing.
module ook_pulse_frame_decoder #(
   parameter int MAX_BITS = 32,
   parameter int MIN_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [oofd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [oofd_pkg::CSR_DATA_W-1:0] csr_wdata,
   oofd_req_if.sink                        req_chan,
   oofd_rsp_if.source                      rsp_chan
);

   oofd_pkg::cfg_type        cfg_ff;
   oofd_pkg::pulse_type      item_ff;
   logic                     item_valid_ff;
   oofd_pkg::result_type     result_ff;
   logic                     result_valid_ff;

   oofd_pkg::match_req_type  match_req;
   oofd_pkg::match_rsp_type  match_rsp;
   oofd_pkg::result_type     result;
   logic                     emit;
   logic                     out_free;
   logic                     step;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_high_us      <= 16'd350;
         cfg_ff.sync_low_us       <= 16'd10850;
         cfg_ff.zero_high_us      <= 16'd350;
         cfg_ff.zero_low_us       <= 16'd1050;
         cfg_ff.one_high_us       <= 16'd1050;
         cfg_ff.one_low_us        <= 16'd350;
         cfg_ff.inverted_mode     <= 1'b0;
         cfg_ff.tolerance_percent <= 7'd25;
      end else if (csr_we) begin
         case (oofd_pkg::csr_index_type'(csr_index))
            oofd_pkg::CSR_SYNC_HIGH: cfg_ff.sync_high_us <= csr_wdata;
            oofd_pkg::CSR_SYNC_LOW:  cfg_ff.sync_low_us  <= csr_wdata;
            oofd_pkg::CSR_ZERO_HIGH: cfg_ff.zero_high_us <= csr_wdata;
            oofd_pkg::CSR_ZERO_LOW:  cfg_ff.zero_low_us  <= csr_wdata;
            oofd_pkg::CSR_ONE_HIGH:  cfg_ff.one_high_us  <= csr_wdata;
            oofd_pkg::CSR_ONE_LOW:   cfg_ff.one_low_us   <= csr_wdata;
            oofd_pkg::CSR_INVERTED:  cfg_ff.inverted_mode <= csr_wdata[0];
            oofd_pkg::CSR_TOLERANCE: begin
               cfg_ff.tolerance_percent <= csr_wdata[oofd_pkg::TOL_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // The pulse in the input register is consumed unless it closes a frame
   // while the result register is still occupied and not being taken.
   assign out_free       = !result_valid_ff || rsp_chan.ready;
   assign step           = item_valid_ff && (!emit || out_free);
   assign req_chan.ready = !item_valid_ff || step;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.pulse_level     <= req_chan.pulse_level;
         item_ff.pulse_length_us <= req_chan.pulse_length_us;
         item_ff.capture_end     <= req_chan.capture_end;
      end
   end

   // Two length checks per pulse, chosen by the current phase.
   oofd_pulse_match u_match_a (
      .nominal    (match_req.nominal_a),
      .tolerance  (cfg_ff.tolerance_percent),
      .want_level (match_req.level_a),
      .level      (item_ff.pulse_level),
      .length     (item_ff.pulse_length_us),
      .fit        (match_rsp.fit_a)
   );

   oofd_pulse_match u_match_b (
      .nominal    (match_req.nominal_b),
      .tolerance  (cfg_ff.tolerance_percent),
      .want_level (match_req.level_b),
      .level      (item_ff.pulse_level),
      .length     (item_ff.pulse_length_us),
      .fit        (match_rsp.fit_b)
   );

   oofd_frame_ctrl #(
      .MAX_BITS (MAX_BITS),
      .MIN_BITS (MIN_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .last      (item_ff.capture_end),
      .cfg       (cfg_ff),
      .match_rsp (match_rsp),
      .match_req (match_req),
      .emit      (emit),
      .result    (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (step && emit) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid     = result_valid_ff;
   assign rsp_chan.code_word = result_ff.code_word;
   assign rsp_chan.bit_count = result_ff.bit_count;
   assign rsp_chan.frame_ok  = result_ff.frame_ok;

   // A frame result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (step && emit) |-> out_free)
      else $error("frame result loaded over an untaken result");

   // A pulse held in the input register stays there until consumed.
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !step) |=> item_valid_ff)
      else $error("held pulse dropped without being consumed");

   // The frame flag agrees with the reported bit count.
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.frame_ok == (32'(rsp_chan.bit_count) >= 32'(MIN_BITS))))
      else $error("frame_ok disagrees with bit_count");

   // No frame reports more bits than a frame may hold.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (32'(rsp_chan.bit_count) <= 32'(MAX_BITS)))
      else $error("bit_count beyond the frame length");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for ook_pulse_frame_decoder: a directed pulse script, then
// random sync frames and noise under several register settings, checked against a predictor.
// Depends on oofd_pkg, oofd_req_if, oofd_rsp_if and the decoder RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD      = 10;
   localparam int RESET_CYCLES    = 10;
   localparam int FRAME_MAX_BITS  = 32;
   localparam int FRAME_MIN_BITS  = 8;
   localparam int SETTLE_CYCLES   = 6;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int SETTING_COUNT   = 6;
   localparam int PULSES_PER_SET  = 118;
   localparam int LEN_MAX         = 65535;

   // Register values that the block comes out of reset with.
   localparam oofd_pkg::cfg_type RESET_CFG = '{
      sync_high_us: 16'd350, sync_low_us: 16'd10850,
      zero_high_us: 16'd350, zero_low_us: 16'd1050,
      one_high_us: 16'd1050, one_low_us: 16'd350,
      inverted_mode: 1'b0, tolerance_percent: 7'd25};

   // Where the decoder stands within a pulse train.
   typedef enum logic [1:0] {
      SEEK_SYNC,
      SYNC_TAIL,
      BIT_HEAD,
      BIT_TAIL
   } seek_state_type;

   // One row of the directed pulse script; frame fields hold only when framed is set.
   typedef struct packed {
      logic                         level;
      logic [oofd_pkg::LEN_W-1:0]   len;
      logic                         last;
      logic                         framed;
      logic [oofd_pkg::CODE_W-1:0]  code;
      logic [oofd_pkg::COUNT_W-1:0] count;
      logic                         ok;
   } script_row_type;

   localparam int SCRIPT_ROWS = 25;
   localparam script_row_type PULSE_SCRIPT [SCRIPT_ROWS] = '{
      // Capture end on a sync-like pulse while hunting, then an oversized mark.
      '{1'b1, 16'd350,   1'b1, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd65535, 1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      // Sync head, then a failed tail that is taken as a new sync head.
      '{1'b1, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd10850, 1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      // A space where a bit head belongs closes an empty frame.
      '{1'b0, 16'd0,     1'b0, 1'b1, 32'd0, 6'd0, 1'b0},
      // Sync at low and high band edges, closed empty by capture end on the tail; then the opposite edges.
      '{1'b1, 16'd262,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd13562, 1'b1, 1'b1, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd437,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd8137,  1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      // A zero, a one, then capture end in the middle of the next pair.
      '{1'b1, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd1050,  1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd1050,  1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd1312,  1'b1, 1'b1, 32'd1, 6'd2, 1'b0},
      // Two ones, the second at the low band edges and ended by capture end.
      '{1'b1, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd10850, 1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd1050,  1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd787,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd262,   1'b1, 1'b1, 32'd3, 6'd2, 1'b0},
      // A zero head followed by a tail that fits nothing.
      '{1'b1, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd10850, 1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b1, 16'd350,   1'b0, 1'b0, 32'd0, 6'd0, 1'b0},
      '{1'b0, 16'd5000,  1'b0, 1'b1, 32'd0, 6'd0, 1'b0}
   };

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [oofd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [oofd_pkg::CSR_DATA_W-1:0] csr_wdata;

   oofd_req_if req_link ();
   oofd_rsp_if rsp_link ();

   ook_pulse_frame_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_link),
      .rsp_chan  (rsp_link)
   );

   // Predictor state and its copy of the registers.
   oofd_pkg::cfg_type            cfg_shadow;
   seek_state_type               dec_state;
   logic [1:0]                   half_fit;
   logic [oofd_pkg::CODE_W-1:0]  code_acc;
   logic [oofd_pkg::COUNT_W-1:0] bit_tally;

   oofd_pkg::result_type expected_frames [$];

   int unsigned fault_count    = 0;
   int unsigned pulses_sent;
   int unsigned frames_checked = 0;
   int unsigned ok_frames      = 0;
   int unsigned full_frames    = 0;
   int unsigned stuck_cycles   = 0;
   int unsigned take_stall     = 0;
   int unsigned take_quiet     = 0;
   bit          send_quiet;

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Band edges of a nominal length under the current tolerance.
   function automatic int unsigned band_lo(input logic [oofd_pkg::LEN_W-1:0] nominal);
      int unsigned t;
      t = (cfg_shadow.tolerance_percent > oofd_pkg::TOL_FULL) ? 100
                                                               : cfg_shadow.tolerance_percent;
      return (int'(nominal) * (100 - t)) / 100;
   endfunction

   function automatic int unsigned band_hi(input logic [oofd_pkg::LEN_W-1:0] nominal);
      int unsigned t;
      t = (cfg_shadow.tolerance_percent > oofd_pkg::TOL_FULL) ? 100
                                                               : cfg_shadow.tolerance_percent;
      return (int'(nominal) * (100 + t)) / 100;
   endfunction

   // A pulse fits when its level is the one the half calls for and its length is in band.
   function automatic bit fits_pulse(input oofd_pkg::pulse_type p, input bit tail,
                                     input logic [oofd_pkg::LEN_W-1:0] nominal);
      logic want;
      want = tail ? cfg_shadow.inverted_mode : ~cfg_shadow.inverted_mode;
      return p.pulse_level == want && p.pulse_length_us >= band_lo(nominal)
             && p.pulse_length_us <= band_hi(nominal);
   endfunction

   task automatic close_frame(output bit framed, output oofd_pkg::result_type frame);
      framed          = 1'b1;
      frame.code_word = code_acc;
      frame.bit_count = bit_tally;
      frame.frame_ok  = (bit_tally >= FRAME_MIN_BITS);
      dec_state       = SEEK_SYNC;
      half_fit        = '0;
      code_acc        = '0;
      bit_tally       = '0;
   endtask

   // Advances the predictor by one pulse and returns the frame it closes, if any.
   task automatic decode_pulse(input oofd_pkg::pulse_type p, output bit framed,
                               output oofd_pkg::result_type frame);
      logic [1:0] fit;
      bit         zero_hit;
      bit         one_hit;
      framed = 1'b0;
      frame  = '0;
      case (dec_state)
         SEEK_SYNC: begin
            if (!p.capture_end && fits_pulse(p, 1'b0, cfg_shadow.sync_high_us))
               dec_state = SYNC_TAIL;
         end
         SYNC_TAIL: begin
            if (fits_pulse(p, 1'b1, cfg_shadow.sync_low_us)) begin
               dec_state = BIT_HEAD;
               code_acc  = '0;
               bit_tally = '0;
               if (p.capture_end)
                  close_frame(framed, frame);
            end else if (!p.capture_end && fits_pulse(p, 1'b0, cfg_shadow.sync_high_us)) begin
               dec_state = SYNC_TAIL;
            end else begin
               dec_state = SEEK_SYNC;
            end
         end
         BIT_HEAD: begin
            fit = {fits_pulse(p, 1'b0, cfg_shadow.one_high_us),
                   fits_pulse(p, 1'b0, cfg_shadow.zero_high_us)};
            if (fit == 2'b00 || p.capture_end) begin
               close_frame(framed, frame);
            end else begin
               half_fit  = fit;
               dec_state = BIT_TAIL;
            end
         end
         default: begin
            // Zero wins when the pair fits both bits.
            zero_hit = half_fit[0] && fits_pulse(p, 1'b1, cfg_shadow.zero_low_us);
            one_hit  = !zero_hit && half_fit[1] && fits_pulse(p, 1'b1, cfg_shadow.one_low_us);
            if (!zero_hit && !one_hit) begin
               close_frame(framed, frame);
            end else begin
               code_acc  = {code_acc[oofd_pkg::CODE_W-2:0], one_hit};
               bit_tally = bit_tally + 1'b1;
               half_fit  = '0;
               if (bit_tally >= FRAME_MAX_BITS || p.capture_end)
                  close_frame(framed, frame);
               else
                  dec_state = BIT_HEAD;
            end
         end
      endcase
   endtask

   // Gap length: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [oofd_pkg::LEN_W-1:0] pick_nominal();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      else if (r < 16)
         return oofd_pkg::LEN_W'(LEN_MAX);
      else if (r < 70)
         return oofd_pkg::LEN_W'($urandom_range(100, 4000));
      else
         return oofd_pkg::LEN_W'($urandom_range(0, LEN_MAX));
   endfunction

   // Length near a nominal: mostly inside the band, sometimes on or just past an edge.
   function automatic logic [oofd_pkg::LEN_W-1:0] pick_len(
      input logic [oofd_pkg::LEN_W-1:0] nominal);
      int unsigned lo;
      int unsigned hi;
      int unsigned r;
      lo = band_lo(nominal);
      hi = band_hi(nominal);
      if (hi > LEN_MAX)
         hi = LEN_MAX;
      r = $urandom_range(0, 99);
      if (r < 78)
         return oofd_pkg::LEN_W'($urandom_range(lo, hi));
      else if (r < 86)
         return oofd_pkg::LEN_W'(lo);
      else if (r < 94)
         return oofd_pkg::LEN_W'(hi);
      else if (lo > 0)
         return oofd_pkg::LEN_W'(lo - 1);
      else if (hi < LEN_MAX)
         return oofd_pkg::LEN_W'(hi + 1);
      else
         return oofd_pkg::LEN_W'($urandom_range(0, LEN_MAX));
   endfunction

   function automatic oofd_pkg::pulse_type make_pulse(input logic level,
                                                      input logic [oofd_pkg::LEN_W-1:0] len,
                                                      input logic last);
      oofd_pkg::pulse_type p;
      p.pulse_level     = level;
      p.pulse_length_us = len;
      p.capture_end     = last;
      return p;
   endfunction

   // Offers one pulse after a random gap, waits for its transfer, then records what it
   // should produce. A typed frame replaces the predicted one. Called and left at a falling
   // edge with valid still up; the next call or the idle wait decides its next value.
   task automatic send_pulse(input oofd_pkg::pulse_type p, input bit typed,
                             input oofd_pkg::result_type typed_frame);
      int unsigned          gap;
      bit                   framed;
      oofd_pkg::result_type frame;
      gap = send_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_link.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_link.valid           <= 1'b1;
      req_link.pulse_level     <= p.pulse_level;
      req_link.pulse_length_us <= p.pulse_length_us;
      req_link.capture_end     <= p.capture_end;
      do
         @(posedge clock);
      while (!(req_link.valid && req_link.ready));
      decode_pulse(p, framed, frame);
      if (typed)
         expected_frames.push_back(typed_frame);
      else if (framed)
         expected_frames.push_back(frame);
      @(negedge clock);
   endtask

   // Random mostly well-formed frame: sync, a random number of bits, one way of ending.
   task automatic send_frame();
      int unsigned nbits;
      int unsigned ending;
      logic        head_lvl;
      logic        tail_lvl;
      logic        one_bit;
      int unsigned r;
      head_lvl = ~cfg_shadow.inverted_mode;
      tail_lvl = cfg_shadow.inverted_mode;
      r        = $urandom_range(0, 99);
      nbits    = (r < 10) ? 0 : (r < 25) ? FRAME_MAX_BITS : $urandom_range(1, FRAME_MAX_BITS - 1);
      ending   = $urandom_range(0, 3);
      send_pulse(make_pulse(head_lvl, pick_len(cfg_shadow.sync_high_us), 1'b0), 1'b0, '0);
      // Now and then a second sync head where the tail belongs.
      if ($urandom_range(0, 9) == 0) begin
         send_pulse(make_pulse(head_lvl, pick_len(cfg_shadow.sync_high_us), 1'b0), 1'b0, '0);
         pulses_sent++;
      end
      send_pulse(make_pulse(tail_lvl, pick_len(cfg_shadow.sync_low_us),
                            nbits == 0 && ending == 2), 1'b0, '0);
      pulses_sent += 2;
      for (int unsigned k = 0; k < nbits; k++) begin
         one_bit = 1'($urandom_range(0, 1));
         send_pulse(make_pulse(head_lvl, pick_len(one_bit ? cfg_shadow.one_high_us
                                                          : cfg_shadow.zero_high_us), 1'b0),
                    1'b0, '0);
         send_pulse(make_pulse(tail_lvl, pick_len(one_bit ? cfg_shadow.one_low_us
                                                          : cfg_shadow.zero_low_us),
                               k == nbits - 1 && ending == 2), 1'b0, '0);
         pulses_sent += 2;
      end
      case (ending)
         0: send_pulse(make_pulse(tail_lvl, oofd_pkg::LEN_W'($urandom_range(0, LEN_MAX)),
                                  1'b0), 1'b0, '0);
         1: begin
            send_pulse(make_pulse(head_lvl, pick_len(cfg_shadow.zero_high_us), 1'b0), 1'b0, '0);
            send_pulse(make_pulse(head_lvl, oofd_pkg::LEN_W'($urandom_range(0, LEN_MAX)),
                                  1'b0), 1'b0, '0);
            pulses_sent++;
         end
         3: send_pulse(make_pulse(head_lvl, pick_len(cfg_shadow.one_high_us), 1'b1), 1'b0, '0);
         default: ;
      endcase
      if (ending != 2)
         pulses_sent++;
   endtask

   // Lowers valid and waits until every expected frame has come and the pipe is empty.
   task automatic wait_idle();
      req_link.valid <= 1'b0;
      while (expected_frames.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes all eight registers, one per cycle, and updates the predictor's copy.
   task automatic write_registers(input oofd_pkg::cfg_type c);
      oofd_pkg::csr_index_type idx;
      for (int i = 0; i < 8; i++) begin
         idx = oofd_pkg::csr_index_type'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         case (idx)
            oofd_pkg::CSR_SYNC_HIGH: csr_wdata <= c.sync_high_us;
            oofd_pkg::CSR_SYNC_LOW:  csr_wdata <= c.sync_low_us;
            oofd_pkg::CSR_ZERO_HIGH: csr_wdata <= c.zero_high_us;
            oofd_pkg::CSR_ZERO_LOW:  csr_wdata <= c.zero_low_us;
            oofd_pkg::CSR_ONE_HIGH:  csr_wdata <= c.one_high_us;
            oofd_pkg::CSR_ONE_LOW:   csr_wdata <= c.one_low_us;
            oofd_pkg::CSR_INVERTED: begin
               csr_wdata <= {{(oofd_pkg::CSR_DATA_W-1){1'b0}}, c.inverted_mode};
            end
            default: begin
               csr_wdata <= {{(oofd_pkg::CSR_DATA_W-oofd_pkg::TOL_W){1'b0}},
                             c.tolerance_percent};
            end
         endcase
         @(negedge clock);
      end
      csr_we     <= 1'b0;
      cfg_shadow  = c;
   endtask

   // Result side: random stalls, with quiet stretches where it always takes.
   always @(negedge clock) begin
      if (take_stall > 0) begin
         rsp_link.ready <= 1'b0;
         take_stall--;
      end else begin
         rsp_link.ready <= 1'b1;
         if (take_quiet > 0) begin
            take_quiet--;
         end else begin
            if ($urandom_range(0, 49) == 0)
               take_quiet = $urandom_range(50, 200);
            take_stall = pick_gap();
         end
      end
   end

   // Each frame transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      oofd_pkg::result_type want;
      oofd_pkg::result_type got;
      if (!reset && rsp_link.valid === 1'b1 && rsp_link.ready) begin
         got.code_word = rsp_link.code_word;
         got.bit_count = rsp_link.bit_count;
         got.frame_ok  = rsp_link.frame_ok;
         if (expected_frames.size() == 0) begin
            fault_count++;
            $display("%0t: unexpected frame code %h count %0d ok %b", $time,
                     got.code_word, got.bit_count, got.frame_ok);
         end else begin
            want = expected_frames.pop_front();
            frames_checked++;
            if (want.frame_ok)
               ok_frames++;
            if (want.bit_count == FRAME_MAX_BITS)
               full_frames++;
            if (got !== want) begin
               fault_count++;
               $display("%0t: frame mismatch, expected code %h count %0d ok %b,",
                        $time, want.code_word, want.bit_count, want.frame_ok);
               $display("   got code %h count %0d ok %b",
                        got.code_word, got.bit_count, got.frame_ok);
            end
         end
      end
   end

   // Watchdog: too long without any transfer on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_link.valid && req_link.ready) || (rsp_link.valid && rsp_link.ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
         $display("ook_pulse_frame_decoder regression: fail");
         $finish;
      end
   end

   initial begin
      oofd_pkg::cfg_type    setting;
      oofd_pkg::result_type typed_frame;
      int unsigned          start_count;
      reset                    = 1'b1;
      csr_we                   = 1'b0;
      csr_index                = '0;
      csr_wdata                = '0;
      req_link.valid           = 1'b0;
      req_link.pulse_level     = 1'b0;
      req_link.pulse_length_us = '0;
      req_link.capture_end     = 1'b0;
      cfg_shadow               = RESET_CFG;
      dec_state                = SEEK_SYNC;
      half_fit                 = '0;
      code_acc                 = '0;
      bit_tally                = '0;
      pulses_sent              = 0;
      send_quiet               = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed script under the reset register values.
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         typed_frame.code_word = PULSE_SCRIPT[i].code;
         typed_frame.bit_count = PULSE_SCRIPT[i].count;
         typed_frame.frame_ok  = PULSE_SCRIPT[i].ok;
         send_pulse(make_pulse(PULSE_SCRIPT[i].level, PULSE_SCRIPT[i].len,
                               PULSE_SCRIPT[i].last), PULSE_SCRIPT[i].framed, typed_frame);
         pulses_sent++;
      end
      wait_idle();

      // Random frames under a series of register settings.
      for (int s = 0; s < SETTING_COUNT; s++) begin
         setting = RESET_CFG;
         case (s)
            0: setting.inverted_mode = 1'b1;
            1: begin
               setting = '{pick_nominal(), pick_nominal(), pick_nominal(), pick_nominal(),
                           pick_nominal(), pick_nominal(), 1'($urandom_range(0, 1)), 7'd0};
            end
            2: begin
               setting = '{16'hFFFF, pick_nominal(), pick_nominal(), 16'd0,
                           pick_nominal(), pick_nominal(), 1'b0, oofd_pkg::TOL_FULL};
            end
            3: begin
               // Tolerance past full scale and bits that share their head lengths, sometimes their tail lengths.
               setting.zero_high_us      = pick_nominal();
               setting.one_high_us       = setting.zero_high_us;
               setting.zero_low_us       = pick_nominal();
               setting.one_low_us        = $urandom_range(0, 1) ? setting.zero_low_us
                                                                : pick_nominal();
               setting.inverted_mode     = 1'b1;
               setting.tolerance_percent = 7'd127;
            end
            4: begin
               setting = '{pick_nominal(), pick_nominal(), pick_nominal(), pick_nominal(),
                           pick_nominal(), pick_nominal(), 1'($urandom_range(0, 1)),
                           7'($urandom_range(0, 100))};
            end
            default: ;
         endcase
         write_registers(setting);
         start_count = pulses_sent;
         while (pulses_sent - start_count < PULSES_PER_SET) begin
            send_quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 12) begin
               // Noise pulses, near the sync length or anywhere.
               repeat ($urandom_range(1, 3)) begin
                  send_pulse(make_pulse(1'($urandom_range(0, 1)),
                                        $urandom_range(0, 1)
                                           ? pick_len(cfg_shadow.sync_high_us)
                                           : oofd_pkg::LEN_W'($urandom_range(0, LEN_MAX)),
                                        $urandom_range(0, 7) == 0), 1'b0, '0);
                  pulses_sent++;
               end
            end else begin
               send_frame();
            end
         end
         wait_idle();
      end

      $display("Sent %0d pulses across the reset setting and %0d written register settings.",
               pulses_sent, SETTING_COUNT);
      $display("Checked %0d frames: %0d with at least eight bits, %0d stopped at full length.",
               frames_checked, ok_frames, full_frames);
      if (fault_count == 0)
         $display("ook_pulse_frame_decoder regression: pass");
      else
         $display("ook_pulse_frame_decoder regression: fail");
      $finish;
   end

endmodule
